### src/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// shared types and constants of the polygon plane clipper: item structs,
// configuration, controller states and the controller/datapath signal groups
// ----------------------------------------------------------------------------
package ppc_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int COUNT_SAT    = ((2 * MAX_VERTICES) < 127) ? (2 * MAX_VERTICES) : 127;

    localparam int COORD_W   = 32;
    localparam int NORM_W    = 18;
    localparam int OFFSET_W  = 32;
    localparam int COUNT_W   = 7;
    localparam int PROD_W    = NORM_W + COORD_W;
    // |n.v - offset| < 2^50, two bits of margin
    localparam int DIST_W    = 52;
    // crossing fraction, one integer bit and 32 fraction bits
    localparam int T_W       = 33;
    localparam int DIV_STEPS = T_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int COORDS    = 3;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic signed [NORM_W-1:0] NORMAL_Z_RESET = 18'sd65536;

    typedef struct packed {
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic signed [COORD_W-1:0] vz;
        logic                      final_vertex;
    } vertex_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic signed [COORD_W-1:0] oz;
        logic                      count_item;
        logic [COUNT_W-1:0]        kept_count;
        logic                      run_end;
    } result_t;

    typedef struct packed {
        logic signed [NORM_W-1:0]   normal_x;
        logic signed [NORM_W-1:0]   normal_y;
        logic signed [NORM_W-1:0]   normal_z;
        logic signed [OFFSET_W-1:0] plane_offset;
    } cfg_t;

    typedef enum logic [1:0] {
        REG_NORMAL_X,
        REG_NORMAL_Y,
        REG_NORMAL_Z,
        REG_PLANE_OFFSET
    } reg_idx_t;

    typedef enum logic [2:0] {
        DOP_NONE,
        DOP_X,
        DOP_Y,
        DOP_Z,
        DOP_ACC
    } dist_op_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_CROSS,
        EMIT_VERTEX,
        EMIT_COUNT
    } emit_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_Z,
        ST_ACC,
        ST_START,
        ST_EDGE,
        ST_DIV_INIT,
        ST_DIV,
        ST_IMUL,
        ST_IADD,
        ST_EMIT_CROSS,
        ST_EMIT_VERTEX,
        ST_COMMIT,
        ST_EMIT_COUNT
    } state_t;

    typedef struct packed {
        logic     load_cur;
        dist_op_t dist_op;
        logic     capture_first;
        logic     commit_prev;
        logic     edge_sel;
        logic     div_init;
        logic     div_step;
        logic     interp_mul;
        logic     interp_add;
        emit_t    emit;
        logic     run_end;
    } ctrl_cmd_t;

    typedef struct packed {
        logic at_start;
        logic final_v;
        logic a_in;
        logic b_in;
        logic div_done;
        logic interp_last;
        logic out_free;
    } dp_status_t;

endpackage

### src/ppc_cfg.sv
// ----------------------------------------------------------------------------
// ppc_cfg
// apb register file holding the plane normal and plane offset
// ----------------------------------------------------------------------------
module ppc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppc_pkg::ADDR_W-1:0]  paddr,
    input  logic [ppc_pkg::DATA_W-1:0]  pwdata,
    output logic [ppc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ppc_pkg::cfg_t               cfg
);

    ppc_pkg::cfg_t     cfg_reg;
    ppc_pkg::cfg_t     cfg_next;
    ppc_pkg::reg_idx_t idx;
    logic              wr;

    assign idx    = ppc_pkg::reg_idx_t'(paddr[ppc_pkg::ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                ppc_pkg::REG_NORMAL_X:     cfg_next.normal_x     = pwdata[ppc_pkg::NORM_W-1:0];
                ppc_pkg::REG_NORMAL_Y:     cfg_next.normal_y     = pwdata[ppc_pkg::NORM_W-1:0];
                ppc_pkg::REG_NORMAL_Z:     cfg_next.normal_z     = pwdata[ppc_pkg::NORM_W-1:0];
                ppc_pkg::REG_PLANE_OFFSET: cfg_next.plane_offset = pwdata[ppc_pkg::OFFSET_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // read back sign extended
    always_comb
    begin
        case (idx)
            ppc_pkg::REG_NORMAL_X:
                prdata = {{(ppc_pkg::DATA_W-ppc_pkg::NORM_W){cfg_reg.normal_x[ppc_pkg::NORM_W-1]}},
                          cfg_reg.normal_x};
            ppc_pkg::REG_NORMAL_Y:
                prdata = {{(ppc_pkg::DATA_W-ppc_pkg::NORM_W){cfg_reg.normal_y[ppc_pkg::NORM_W-1]}},
                          cfg_reg.normal_y};
            ppc_pkg::REG_NORMAL_Z:
                prdata = {{(ppc_pkg::DATA_W-ppc_pkg::NORM_W){cfg_reg.normal_z[ppc_pkg::NORM_W-1]}},
                          cfg_reg.normal_z};
            ppc_pkg::REG_PLANE_OFFSET:
                prdata = cfg_reg.plane_offset;
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.normal_x     <= '0;
            cfg_reg.normal_y     <= '0;
            cfg_reg.normal_z     <= ppc_pkg::NORMAL_Z_RESET;
            cfg_reg.plane_offset <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### src/ppc_ctrl.sv
// ----------------------------------------------------------------------------
// ppc_ctrl
// sequencer: distance, edge classification, divide, interpolate and emit
// ----------------------------------------------------------------------------
module ppc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   vtx_valid,
    output logic                   vtx_ready,
    input  ppc_pkg::dp_status_t    st,
    output ppc_pkg::ctrl_cmd_t     cmd
);

    ppc_pkg::state_t state_reg;
    ppc_pkg::state_t state_next;
    logic            edge_sel_reg;
    logic            edge_sel_next;
    ppc_pkg::state_t edge_done_state;

    // after the polygon edge comes the commit, after the closing edge the count
    assign edge_done_state = edge_sel_reg ? ppc_pkg::ST_EMIT_COUNT : ppc_pkg::ST_COMMIT;

    always_comb
    begin
        state_next    = state_reg;
        edge_sel_next = edge_sel_reg;
        case (state_reg)
            ppc_pkg::ST_IDLE:
            begin
                if (vtx_valid)
                    state_next = ppc_pkg::ST_MUL_X;
            end
            ppc_pkg::ST_MUL_X: state_next = ppc_pkg::ST_MUL_Y;
            ppc_pkg::ST_MUL_Y: state_next = ppc_pkg::ST_MUL_Z;
            ppc_pkg::ST_MUL_Z: state_next = ppc_pkg::ST_ACC;
            ppc_pkg::ST_ACC:   state_next = ppc_pkg::ST_START;
            ppc_pkg::ST_START:
            begin
                edge_sel_next = 1'b0;
                state_next    = st.at_start ? ppc_pkg::ST_COMMIT : ppc_pkg::ST_EDGE;
            end
            ppc_pkg::ST_EDGE:
            begin
                if (st.a_in && st.b_in)
                    state_next = ppc_pkg::ST_EMIT_VERTEX;
                else if (st.a_in || st.b_in)
                    state_next = ppc_pkg::ST_DIV_INIT;
                else
                    state_next = edge_done_state;
            end
            ppc_pkg::ST_DIV_INIT: state_next = ppc_pkg::ST_DIV;
            ppc_pkg::ST_DIV:
            begin
                if (st.div_done)
                    state_next = ppc_pkg::ST_IMUL;
            end
            ppc_pkg::ST_IMUL: state_next = ppc_pkg::ST_IADD;
            ppc_pkg::ST_IADD:
            begin
                state_next = st.interp_last ? ppc_pkg::ST_EMIT_CROSS : ppc_pkg::ST_IMUL;
            end
            ppc_pkg::ST_EMIT_CROSS:
            begin
                if (st.out_free)
                    state_next = st.b_in ? ppc_pkg::ST_EMIT_VERTEX : edge_done_state;
            end
            ppc_pkg::ST_EMIT_VERTEX:
            begin
                if (st.out_free)
                    state_next = edge_done_state;
            end
            ppc_pkg::ST_COMMIT:
            begin
                if (st.final_v)
                begin
                    edge_sel_next = 1'b1;
                    state_next    = ppc_pkg::ST_EDGE;
                end
                else
                begin
                    state_next = ppc_pkg::ST_IDLE;
                end
            end
            ppc_pkg::ST_EMIT_COUNT:
            begin
                if (st.out_free)
                    state_next = ppc_pkg::ST_IDLE;
            end
            default: state_next = ppc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        vtx_ready         = 1'b0;
        cmd               = '0;
        cmd.dist_op       = ppc_pkg::DOP_NONE;
        cmd.emit          = ppc_pkg::EMIT_NONE;
        cmd.edge_sel      = edge_sel_reg;
        case (state_reg)
            ppc_pkg::ST_IDLE:
            begin
                vtx_ready    = 1'b1;
                cmd.load_cur = vtx_valid;
            end
            ppc_pkg::ST_MUL_X:    cmd.dist_op = ppc_pkg::DOP_X;
            ppc_pkg::ST_MUL_Y:    cmd.dist_op = ppc_pkg::DOP_Y;
            ppc_pkg::ST_MUL_Z:    cmd.dist_op = ppc_pkg::DOP_Z;
            ppc_pkg::ST_ACC:      cmd.dist_op = ppc_pkg::DOP_ACC;
            ppc_pkg::ST_START:    cmd.capture_first = st.at_start;
            ppc_pkg::ST_EDGE:     cmd.capture_first = 1'b0;
            ppc_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
            ppc_pkg::ST_DIV:      cmd.div_step = 1'b1;
            ppc_pkg::ST_IMUL:     cmd.interp_mul = 1'b1;
            ppc_pkg::ST_IADD:     cmd.interp_add = 1'b1;
            ppc_pkg::ST_EMIT_CROSS:
            begin
                cmd.emit    = st.out_free ? ppc_pkg::EMIT_CROSS : ppc_pkg::EMIT_NONE;
                cmd.run_end = !edge_sel_reg && !st.final_v && !st.b_in;
            end
            ppc_pkg::ST_EMIT_VERTEX:
            begin
                cmd.emit    = st.out_free ? ppc_pkg::EMIT_VERTEX : ppc_pkg::EMIT_NONE;
                cmd.run_end = !edge_sel_reg && !st.final_v;
            end
            ppc_pkg::ST_COMMIT:   cmd.commit_prev = 1'b1;
            ppc_pkg::ST_EMIT_COUNT:
            begin
                cmd.emit    = st.out_free ? ppc_pkg::EMIT_COUNT : ppc_pkg::EMIT_NONE;
                cmd.run_end = 1'b1;
            end
            default:              vtx_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ppc_pkg::ST_IDLE;
            edge_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            edge_sel_reg <= edge_sel_next;
        end
    end

endmodule

### src/ppc_dpath.sv
// ----------------------------------------------------------------------------
// ppc_dpath
// vertex and distance storage, shared distance multiplier, restoring divider,
// interpolation multiplier, vertex count and the result register
// ----------------------------------------------------------------------------
module ppc_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ppc_pkg::cfg_t        cfg,
    input  ppc_pkg::vertex_t     vtx_data,
    input  ppc_pkg::ctrl_cmd_t   cmd,
    output ppc_pkg::dp_status_t  st,
    output logic                 res_valid,
    input  logic                 res_ready,
    output ppc_pkg::result_t     res_data
);

    localparam int CW = ppc_pkg::COORD_W;
    localparam int DW = ppc_pkg::DIST_W;
    localparam int PW = ppc_pkg::PROD_W;
    localparam int NC = ppc_pkg::COORDS;

    // vertex and distance state
    logic signed [CW-1:0] cur_reg   [NC];
    logic signed [CW-1:0] cur_next  [NC];
    logic signed [CW-1:0] prev_reg  [NC];
    logic signed [CW-1:0] prev_next [NC];
    logic signed [CW-1:0] first_reg [NC];
    logic signed [CW-1:0] first_next[NC];
    logic [CW-1:0]        cross_reg [NC];
    logic [CW-1:0]        cross_next[NC];
    logic                 final_reg;
    logic                 final_next;
    logic signed [PW-1:0] dprod_reg;
    logic signed [PW-1:0] dprod_next;
    logic signed [DW-1:0] acc_reg;
    logic signed [DW-1:0] acc_next;
    logic signed [DW-1:0] prev_d_reg;
    logic signed [DW-1:0] prev_d_next;
    logic signed [DW-1:0] first_d_reg;
    logic signed [DW-1:0] first_d_next;

    // divider
    logic [DW:0]                      den_reg;
    logic [DW:0]                      den_next;
    logic [DW:0]                      rem_reg;
    logic [DW:0]                      rem_next;
    logic [ppc_pkg::T_W-1:0]          t_reg;
    logic [ppc_pkg::T_W-1:0]          t_next;
    logic [ppc_pkg::DIV_CNT_W-1:0]    div_cnt_reg;
    logic [ppc_pkg::DIV_CNT_W-1:0]    div_cnt_next;

    // interpolation
    logic [1:0]       idx_reg;
    logic [1:0]       idx_next;
    logic [63:0]      iprod_reg;
    logic [63:0]      iprod_next;
    logic             neg_reg;
    logic             neg_next;

    // count and polygon state
    logic [ppc_pkg::COUNT_W-1:0] count_reg;
    logic [ppc_pkg::COUNT_W-1:0] count_next;
    logic                        at_start_reg;
    logic                        at_start_next;

    logic              res_valid_reg;
    logic              res_valid_next;
    ppc_pkg::result_t  res_data_reg;
    ppc_pkg::result_t  res_data_next;

    // combinational helpers
    logic signed [ppc_pkg::NORM_W-1:0] mul_n;
    logic signed [CW-1:0]              mul_v;
    logic signed [PW-1:0]              dprod;
    logic signed [DW-1:0]              off_ext;
    logic signed [DW-1:0]              dprod_ext;
    logic signed [DW-1:0]              da;
    logic signed [DW-1:0]              db;
    logic signed [CW-1:0]              a_c [NC];
    logic signed [CW-1:0]              b_c [NC];
    logic signed [DW:0]                dd;
    logic [DW:0]                       den_mag;
    logic [DW-1:0]                     da_mag;
    logic [DW+1:0]                     shifted;
    logic [DW+1:0]                     sub;
    logic                              ge;
    logic [CW-1:0]                     ia;
    logic [CW-1:0]                     ib;
    logic [CW:0]                       cdiff;
    logic [CW:0]                       cmag;
    logic [63:0]                       imul;
    logic [63:0]                       round;
    logic [CW-1:0]                     cross_val;
    logic [ppc_pkg::COUNT_W-1:0]       count_inc;

    // distance multiplier operands
    always_comb
    begin
        case (cmd.dist_op)
            ppc_pkg::DOP_X:
            begin
                mul_n = cfg.normal_x;
                mul_v = cur_reg[0];
            end
            ppc_pkg::DOP_Y:
            begin
                mul_n = cfg.normal_y;
                mul_v = cur_reg[1];
            end
            ppc_pkg::DOP_Z:
            begin
                mul_n = cfg.normal_z;
                mul_v = cur_reg[2];
            end
            default:
            begin
                mul_n = cfg.normal_x;
                mul_v = cur_reg[0];
            end
        endcase
    end

    assign dprod     = mul_n * mul_v;
    assign off_ext   = {{(DW-ppc_pkg::OFFSET_W-16){cfg.plane_offset[ppc_pkg::OFFSET_W-1]}},
                        cfg.plane_offset, 16'h0000};
    assign dprod_ext = {{(DW-PW){dprod_reg[PW-1]}}, dprod_reg};

    // edge endpoints: previous to current, or current to first on the closing edge
    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            a_c[i] = cmd.edge_sel ? cur_reg[i]   : prev_reg[i];
            b_c[i] = cmd.edge_sel ? first_reg[i] : cur_reg[i];
        end
        da = cmd.edge_sel ? acc_reg     : prev_d_reg;
        db = cmd.edge_sel ? first_d_reg : acc_reg;
    end

    assign dd      = {da[DW-1], da} - {db[DW-1], db};
    assign den_mag = dd[DW] ? (DW+1)'(-dd) : dd;
    assign da_mag  = da[DW-1] ? DW'(-da) : da;

    // one quotient bit per cycle, no shift on the integer bit
    assign shifted = (div_cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign sub     = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    // coordinate interpolation, t of exactly one passes the magnitude through
    assign ia        = a_c[idx_reg];
    assign ib        = b_c[idx_reg];
    assign cdiff     = {ib[CW-1], ib} - {ia[CW-1], ia};
    assign cmag      = cdiff[CW] ? (CW+1)'(-cdiff) : cdiff;
    assign imul      = cmag[CW-1:0] * t_reg[ppc_pkg::T_W-2:0];
    assign round     = iprod_reg + 64'h0000_0000_8000_0000;
    assign cross_val = neg_reg ? (ia - round[63:32]) : (ia + round[63:32]);

    assign count_inc = (count_reg < ppc_pkg::COUNT_W'(ppc_pkg::COUNT_SAT))
                       ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        first_next    = first_reg;
        cross_next    = cross_reg;
        final_next    = final_reg;
        dprod_next    = dprod_reg;
        acc_next      = acc_reg;
        prev_d_next   = prev_d_reg;
        first_d_next  = first_d_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        t_next        = t_reg;
        div_cnt_next  = div_cnt_reg;
        idx_next      = idx_reg;
        iprod_next    = iprod_reg;
        neg_next      = neg_reg;
        count_next    = count_reg;
        at_start_next = at_start_reg;
        res_data_next = res_data_reg;

        if (cmd.load_cur)
        begin
            cur_next[0] = vtx_data.vx;
            cur_next[1] = vtx_data.vy;
            cur_next[2] = vtx_data.vz;
            final_next  = vtx_data.final_vertex;
        end

        case (cmd.dist_op)
            ppc_pkg::DOP_X:
            begin
                dprod_next = dprod;
                acc_next   = -off_ext;
            end
            ppc_pkg::DOP_Y, ppc_pkg::DOP_Z:
            begin
                dprod_next = dprod;
                acc_next   = acc_reg + dprod_ext;
            end
            ppc_pkg::DOP_ACC: acc_next = acc_reg + dprod_ext;
            default:          acc_next = acc_reg;
        endcase

        if (cmd.capture_first)
        begin
            first_next    = cur_reg;
            first_d_next  = acc_reg;
            count_next    = '0;
            at_start_next = 1'b0;
        end

        if (cmd.commit_prev)
        begin
            prev_next   = cur_reg;
            prev_d_next = acc_reg;
        end

        if (cmd.div_init)
        begin
            den_next     = den_mag;
            rem_next     = {1'b0, da_mag};
            t_next       = '0;
            div_cnt_next = '0;
            idx_next     = '0;
        end

        if (cmd.div_step)
        begin
            rem_next     = ge ? sub[DW:0] : shifted[DW:0];
            t_next       = {t_reg[ppc_pkg::T_W-2:0], ge};
            div_cnt_next = div_cnt_reg + 1'b1;
        end

        if (cmd.interp_mul)
        begin
            iprod_next = t_reg[ppc_pkg::T_W-1] ? {cmag[CW-1:0], 32'h0000_0000} : imul;
            neg_next   = cdiff[CW];
        end

        if (cmd.interp_add)
        begin
            cross_next[idx_reg] = cross_val;
            idx_next            = idx_reg + 1'b1;
        end

        case (cmd.emit)
            ppc_pkg::EMIT_CROSS:
            begin
                res_data_next.ox         = cross_reg[0];
                res_data_next.oy         = cross_reg[1];
                res_data_next.oz         = cross_reg[2];
                res_data_next.count_item = 1'b0;
                res_data_next.kept_count = '0;
                res_data_next.run_end    = cmd.run_end;
                count_next               = count_inc;
            end
            ppc_pkg::EMIT_VERTEX:
            begin
                res_data_next.ox         = b_c[0];
                res_data_next.oy         = b_c[1];
                res_data_next.oz         = b_c[2];
                res_data_next.count_item = 1'b0;
                res_data_next.kept_count = '0;
                res_data_next.run_end    = cmd.run_end;
                count_next               = count_inc;
            end
            ppc_pkg::EMIT_COUNT:
            begin
                res_data_next.ox         = '0;
                res_data_next.oy         = '0;
                res_data_next.oz         = '0;
                res_data_next.count_item = 1'b1;
                res_data_next.kept_count = count_reg;
                res_data_next.run_end    = cmd.run_end;
                count_next               = '0;
                at_start_next            = 1'b1;
            end
            default: res_data_next = res_data_reg;
        endcase
    end

    always_comb
    begin
        if (cmd.emit != ppc_pkg::EMIT_NONE)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    assign st.at_start    = at_start_reg;
    assign st.final_v     = final_reg;
    assign st.a_in        = da[DW-1] || (da == '0);
    assign st.b_in        = db[DW-1] || (db == '0);
    assign st.div_done    = (div_cnt_reg == ppc_pkg::DIV_CNT_W'(ppc_pkg::DIV_STEPS - 1));
    assign st.interp_last = (idx_reg == 2'(NC - 1));
    assign st.out_free    = !res_valid_reg || res_ready;

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            at_start_reg  <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            at_start_reg  <= at_start_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        first_reg    <= first_next;
        cross_reg    <= cross_next;
        final_reg    <= final_next;
        dprod_reg    <= dprod_next;
        acc_reg      <= acc_next;
        prev_d_reg   <= prev_d_next;
        first_d_reg  <= first_d_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        t_reg        <= t_next;
        div_cnt_reg  <= div_cnt_next;
        idx_reg      <= idx_next;
        iprod_reg    <= iprod_next;
        neg_reg      <= neg_next;
        res_data_reg <= res_data_next;
    end

endmodule

### src/polygon_plane_clipper.sv
// ----------------------------------------------------------------------------
// polygon_plane_clipper
// single plane sutherland-hodgman clipper on q16.16 vertices, one vertex per
// item, a count item closes each polygon
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload             role
//  vtx       vtx_valid/vtx_ready  ppc_pkg::vertex_t   vertex in, final_vertex ends polygon
//  res       res_valid/res_ready  ppc_pkg::result_t   kept vertices, crossings, count item
//  apb       psel/penable/pready  pwdata/prdata       normal_x/y/z, plane_offset
//
//  each vertex runs the distance steps (x, y, z products, accumulate), then the
//  edge test unless it opens a polygon, then its results; the last vertex adds
//  the closing edge test
//  each crossing edge runs the 33-step restoring divider for the
//  crossing fraction, then the three coordinates through one multiplier
//  one vertex is in work at a time; the next is taken once the sequencer is idle,
//  while the last result may still sit in the result register
//  a stalled result register holds the sequencer in its emit state
//  rst_n clears the sequencer, vertex count and result valid and sets the polygon start flag at once
//
module polygon_plane_clipper (
    input  logic                        clk,
    input  logic                        rst_n,
    // vertex channel
    input  logic                        vtx_valid,
    output logic                        vtx_ready,
    input  ppc_pkg::vertex_t            vtx_data,
    // result channel
    output logic                        res_valid,
    input  logic                        res_ready,
    output ppc_pkg::result_t            res_data,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppc_pkg::ADDR_W-1:0]  paddr,
    input  logic [ppc_pkg::DATA_W-1:0]  pwdata,
    output logic [ppc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    // plane registers
    ppc_pkg::cfg_t       cfg;
    // sequencer commands and datapath status
    ppc_pkg::ctrl_cmd_t  cmd;
    ppc_pkg::dp_status_t st;

    ppc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // state machine walks distance, edge test, divide, interpolate, emit
    ppc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // storage, arithmetic and the result register
    ppc_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .vtx_data  (vtx_data),
        .cmd       (cmd),
        .st        (st),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

### src/ppc_checker.sv
// ----------------------------------------------------------------------------
// ppc_checker
// port level checks of the polygon plane clipper, bound to the top level
// ----------------------------------------------------------------------------
module ppc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              vtx_valid,
    input logic              vtx_ready,
    input logic              res_valid,
    input logic              res_ready,
    input ppc_pkg::result_t  res_data
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // one vertex in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        vtx_valid && vtx_ready |=> !vtx_ready)
        else $error("vertex taken while busy");

    // count item closes the polygon with zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.count_item |->
            res_data.run_end && res_data.ox == '0 && res_data.oy == '0 && res_data.oz == '0)
        else $error("malformed count item");

    // vertex items carry no count
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.count_item |-> res_data.kept_count == '0)
        else $error("count on vertex item");

    // count saturates
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.kept_count <= ppc_pkg::COUNT_W'(ppc_pkg::COUNT_SAT))
        else $error("count above saturation");

endmodule

bind polygon_plane_clipper ppc_checker u_ppc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);
